// ----- sv/pipc_pkg.sv -----
// Package with shared types and constants of the point-in-polygon crossing core.
package pipc_pkg;

  localparam int MAX_VERTICES_DEF = 32;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_TEST   = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } vertex_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               new_polygon;
  } item_t;

  typedef struct packed {
    logic inside_res;
    logic polygon_truncated;
  } result_t;

endpackage

// ----- sv/point_in_polygon_crossing_core.sv -----
// Top level of the even-odd point-in-polygon core: vertex ring, sequencer and edge unit.
//
// Usage: items arrive on the item channel (item_valid / item_ready / item). An append
// item (op = OP_APPEND) stores one vertex in a ring of MAX_VERTICES cells;
// with new_polygon set the ring is emptied first and the truncation flag is cleared.
// Vertices beyond the ring's size are dropped and set the truncation flag. A test item
// (op = OP_TEST) rotates the ring once, one vertex per cycle, and feeds each edge,
// the closing edge included, to a three-stage edge unit that does the exact
// cross-multiplied compare and toggles the parity flag.
// A test steps the ring through every stored vertex, then issues the closing edge, then
// drains while the last edges leave the edge unit, and then raises result_valid.
// An empty polygon goes straight to the drain state. The next item can make its transfer
// in the cycle in which result_valid rises. Appends are taken one per cycle while no test
// is running. One result (inside_res, polygon_truncated) is returned per test; none per
// append.
// The result sits in an output register, so appends and the next test are taken while
// an earlier result waits; a finished test holds in its drain state only while the
// receiver stalls with a result still pending. Reset empties the polygon, clears the
// flag and drops any pending result; vertex storage itself is not cleared.
module point_in_polygon_crossing_core
  import pipc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_CLOSE,
    ST_DRAIN
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic               overflow;
  logic [CW-1:0]      step;
  logic signed [31:0] tx;
  logic signed [31:0] ty;
  vertex_t            first;
  vertex_t            prev;

  vertex_t            cells [MAX_VERTICES];
  vertex_t            head;
  vertex_t            new_vtx;
  vertex_t            edge_vi;
  logic               item_xfer;
  logic               append_xfer;
  logic               test_xfer;
  logic [CW-1:0]      eff_count;
  logic               room;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  logic [IW-1:0]      last_idx;
  logic               shift;
  logic               issue;
  logic               parity;
  logic               edge_idle;
  logic               result_free;
  logic               result_load;

  assign head       = cells[0];
  assign item_ready = (state == ST_IDLE);
  assign item_xfer  = item_valid && item_ready;
  assign append_xfer = item_xfer && (item.op == OP_APPEND);
  assign test_xfer  = item_xfer && (item.op == OP_TEST);

  // Append: an empty request restarts the list at entry zero.
  assign eff_count = item.new_polygon ? '0 : count;
  assign room      = eff_count < MAX_CNT;
  assign wr_en     = append_xfer && room;
  assign wr_idx    = eff_count[IW-1:0];
  assign new_vtx.x = item.coord_x;
  assign new_vtx.y = item.coord_y;

  // During a test every cell shifts toward the head; the last stored one wraps around,
  // so after count rotations the ring is back in its original order.
  assign shift    = (state == ST_RUN);
  assign last_idx = IW'(count - CW'(1));

  // Edge (v[k-1], v[k]) is issued on rotation step k; the closing edge uses the saved head.
  assign issue   = ((state == ST_RUN) && (step != '0)) || (state == ST_CLOSE);
  assign edge_vi = (state == ST_CLOSE) ? first : head;

  assign result_free = !result_valid || result_ready;
  // The verdict is loaded once the edge unit is empty and the output register is free.
  assign result_load = (state == ST_DRAIN) && edge_idle && result_free;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    if (k < MAX_VERTICES - 1) begin : g_mid
      pipc_cell #(.IW(IW), .IDX(k)) u_cell (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (new_vtx),
        .shift     (shift),
        .last_idx  (last_idx),
        .from_next (cells[k+1]),
        .from_head (head),
        .vtx       (cells[k])
      );
    end else begin : g_tail
      pipc_cell #(.IW(IW), .IDX(k)) u_cell (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (new_vtx),
        .shift     (shift),
        .last_idx  (last_idx),
        .from_next (head),
        .from_head (head),
        .vtx       (cells[k])
      );
    end
  end

  pipc_edge u_edge (
    .clk    (clk),
    .rst    (rst),
    .clr    (test_xfer),
    .issue  (issue),
    .vi     (edge_vi),
    .vj     (prev),
    .tx     (tx),
    .ty     (ty),
    .parity (parity),
    .idle   (edge_idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      overflow     <= 1'b0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (append_xfer) begin
            count    <= room ? eff_count + CW'(1) : eff_count;
            overflow <= (item.new_polygon ? 1'b0 : overflow) || !room;
          end else if (test_xfer) begin
            tx   <= item.coord_x;
            ty   <= item.coord_y;
            step <= '0;
            state <= (count == '0) ? ST_DRAIN : ST_RUN;
          end
        end
        ST_RUN: begin
          prev <= head;
          if (step == '0) begin
            first <= head;
          end
          if (step == count - CW'(1)) begin
            state <= ST_CLOSE;
          end else begin
            step <= step + CW'(1);
          end
        end
        ST_CLOSE: begin
          state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (result_load) begin
            result.inside_res        <= parity;
            result.polygon_truncated <= overflow;
            state                    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/pipc_cell.sv -----
// One vertex cell of the polygon ring: holds a vertex, loads it on append, rotates on test.
module pipc_cell
  import pipc_pkg::*;
#(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  vertex_t       wr_data,
  input  logic          shift,
  input  logic [IW-1:0] last_idx,
  input  vertex_t       from_next,
  input  vertex_t       from_head,
  output vertex_t       vtx
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // The cell holding the last stored vertex wraps around to the head.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      vtx <= wr_data;
    end else if (shift) begin
      vtx <= (last_idx == MY_IDX) ? from_head : from_next;
    end
  end

endmodule

// ----- sv/pipc_edge.sv -----
// Pipelined edge unit: straddle check, exact cross-multiplied compare and parity toggle.
module pipc_edge
  import pipc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               clr,
  input  logic               issue,
  input  vertex_t            vi,
  input  vertex_t            vj,
  input  logic signed [31:0] tx,
  input  logic signed [31:0] ty,
  output logic               parity,
  output logic               idle
);

  logic               straddle;
  logic signed [32:0] diff_a;
  logic signed [32:0] diff_d;
  logic signed [32:0] diff_b;
  logic signed [32:0] diff_c;

  logic               s1_v;
  logic               s1_dneg;
  logic signed [32:0] s1_a;
  logic signed [32:0] s1_d;
  logic signed [32:0] s1_b;
  logic signed [32:0] s1_c;

  logic               s2_v;
  logic               s2_dneg;
  logic signed [65:0] prod_l;
  logic signed [65:0] prod_r;
  logic signed [65:0] s2_l;
  logic signed [65:0] s2_r;
  logic               hit;

  assign straddle = (vi.y > ty) != (vj.y > ty);
  assign diff_a   = 33'(tx) - 33'(vi.x);
  assign diff_d   = 33'(vj.y) - 33'(vi.y);
  assign diff_b   = 33'(vj.x) - 33'(vi.x);
  assign diff_c   = 33'(ty) - 33'(vi.y);

  assign prod_l = s1_a * s1_d;
  assign prod_r = s1_b * s1_c;

  // A straddling edge never has zero height, so the sign of d picks the direction.
  assign hit  = s2_dneg ? (s2_r < s2_l) : (s2_l < s2_r);
  assign idle = !s1_v && !s2_v;

  always_ff @(posedge clk) begin
    s1_a    <= diff_a;
    s1_d    <= diff_d;
    s1_b    <= diff_b;
    s1_c    <= diff_c;
    s1_dneg <= diff_d[32];
    s2_l    <= prod_l;
    s2_r    <= prod_r;
    s2_dneg <= s1_dneg;
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      parity <= 1'b0;
    end else begin
      s1_v <= issue && straddle;
      s2_v <= s1_v;
      if (clr) begin
        parity <= 1'b0;
      end else if (s2_v && hit) begin
        parity <= !parity;
      end
    end
  end

endmodule

// ----- sv/pipc_checker.sv -----
// Port-level checker for the point-in-polygon core, bound to the top level.
module pipc_checker
  import pipc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // An append transfer never produces a result.
  a_append_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.op == OP_APPEND) && !result_valid |=> !result_valid)
    else $error("result appeared after an append");

  // A test keeps the block busy in the cycle after its transfer.
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.op == OP_TEST) |=> !item_ready)
    else $error("item taken right after a test transfer");

  // A new result only comes out of a test in progress.
  a_result_from_test: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared while no test was running");

endmodule

bind point_in_polygon_crossing_core pipc_checker u_pipc_checker (.*);
